/* design/dtpc_pkg.sv */
// Shared constants and types for the depth-to-point-cloud block.
package dtpc_pkg;

  // Default for the longest supported row or column count.
  localparam int MAX_LINE_DEF = 4096;

  // Field and register widths.
  localparam int SIZE_W  = 13;
  localparam int FOCAL_W = 12;
  localparam int DEPTH_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int XY_W    = 28;
  localparam int Z_W     = 17;
  localparam int COLOR_W = 8;
  localparam int GREEN_W = 7;

  // Shared multiplier and divider widths.
  localparam int MUL_W = 16;
  localparam int NUM_W = 2 * MUL_W;
  localparam int DEN_W = 16;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_FOCAL_PX     = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEPTH_SCALE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_MIN_RANGE    = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_RANGE    = 3'd5;

  // Register values after reset.
  localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH  = 13'd640;
  localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
  localparam logic [FOCAL_W-1:0] RST_FOCAL_PX     = 12'd525;
  localparam logic [DEPTH_W-1:0] RST_DEPTH_SCALE  = 16'd256;
  localparam logic [DEPTH_W-1:0] RST_MIN_RANGE    = 16'd300;
  localparam logic [DEPTH_W-1:0] RST_MAX_RANGE    = 16'd4000;

  // Pixel position info for one accepted item.
  typedef struct packed {
    logic             keep;
    logic             neg_x;
    logic [MUL_W-1:0] mag_x;
    logic             neg_y;
    logic [MUL_W-1:0] mag_y;
  } pos_info_t;

endpackage

/* design/dtpc_pos.sv */
// Column and row counters with offsets from the principal point.
module dtpc_pos #(
  parameter int MAX_LINE = dtpc_pkg::MAX_LINE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        frame_start,
  input  logic [dtpc_pkg::SIZE_W-1:0] frame_width,
  input  logic [dtpc_pkg::SIZE_W-1:0] frame_height,
  output dtpc_pkg::pos_info_t         info
);
  import dtpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_LINE);
  localparam int SZ_W  = $clog2(MAX_LINE + 1);
  localparam int E_W   = CNT_W + 1;
  localparam int CMP_W = SIZE_W + 1;

  logic [CNT_W-1:0] column_count, row_count;
  logic [CNT_W-1:0] cur_col, cur_row, col_next, row_mid, row_next;
  logic [E_W-1:0]   col_inc, row_inc;
  logic [SZ_W-1:0]  w, h, half_w, half_h, pos_x, pos_y;
  logic             wrap;

  function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return SZ_W'(1);
    end
    if ({1'b0, v} > CMP_W'(MAX_LINE)) begin
      return SZ_W'(MAX_LINE);
    end
    return SZ_W'(v);
  endfunction

  always_comb begin
    w       = clamp_size(frame_width);
    h       = clamp_size(frame_height);
    cur_col = frame_start ? '0 : column_count;
    cur_row = frame_start ? '0 : row_count;
    col_inc = {1'b0, cur_col} + E_W'(1);
    row_inc = {1'b0, cur_row} + E_W'(1);
    wrap    = col_inc >= E_W'(w);
    col_next = wrap ? '0 : col_inc[CNT_W-1:0];
    if (wrap) begin
      row_mid = (row_inc >= E_W'(h)) ? '0 : row_inc[CNT_W-1:0];
    end else begin
      row_mid = cur_row;
    end
    row_next = ({1'b0, row_mid} >= E_W'(h)) ? '0 : row_mid;

    half_w = w >> 1;
    half_h = h >> 1;
    pos_x  = SZ_W'(cur_col);
    pos_y  = SZ_W'(cur_row);
    info.keep = !cur_col[0] && !cur_row[0];
    if (pos_x >= half_w) begin
      info.neg_x = 1'b0;
      info.mag_x = MUL_W'(pos_x - half_w);
    end else begin
      info.neg_x = 1'b1;
      info.mag_x = MUL_W'(half_w - pos_x);
    end
    if (pos_y >= half_h) begin
      info.neg_y = 1'b0;
      info.mag_y = MUL_W'(pos_y - half_h);
    end else begin
      info.neg_y = 1'b1;
      info.mag_y = MUL_W'(half_h - pos_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= col_next;
      row_count    <= row_next;
    end
  end

endmodule

/* design/dtpc_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module dtpc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dtpc_pkg::NUM_W-1:0] num,
  input  logic [dtpc_pkg::DEN_W-1:0] den,
  output logic                       busy,
  output logic                       done,
  output logic [dtpc_pkg::NUM_W-1:0] quo
);
  import dtpc_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem, den_q;
  logic [DEN_W:0]   rem_sh, diff;
  logic [CNT_W-1:0] cnt;
  logic             fits;

  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    fits   = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      den_q <= den;
      rem   <= '0;
      cnt   <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

/* design/depth_to_point_cloud.sv */
// Depth-to-point-cloud back-projection: top level with sequencer and shared multiplier.
// A skipped or invalid pixel, or one outside the depth window, produces no result.
// A kept pixel makes three passes through the 32-step shared divider (x offset,
// y offset, color ramp).
// Reset (synchronous, active high) restores the register defaults, clears the counters
// and drops any pending result.
module depth_to_point_cloud #(
  parameter int MAX_LINE = dtpc_pkg::MAX_LINE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                cfg_write,
  input  logic [dtpc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [dtpc_pkg::CFG_W-1:0]          cfg_data,
  // Input items.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dtpc_pkg::DEPTH_W-1:0]        depth_raw,
  input  logic                                frame_start,
  // Result items.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dtpc_pkg::XY_W-1:0]    x_mm,
  output logic signed [dtpc_pkg::XY_W-1:0]    y_mm,
  output logic signed [dtpc_pkg::Z_W-1:0]     z_mm,
  output logic [dtpc_pkg::COLOR_W-1:0]        red,
  output logic [dtpc_pkg::GREEN_W-1:0]        green,
  output logic [dtpc_pkg::COLOR_W-1:0]        blue
);
  import dtpc_pkg::*;

  // The sequencer walks one kept pixel through scaling, the window check and
  // three multiply-then-divide passes before it parks the result.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCALE  = 7'b0000010,
    ST_CHECK  = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_DSTART = 7'b0010000,
    ST_DWAIT  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    STEP_X   = 2'd0,
    STEP_Y   = 2'd1,
    STEP_RED = 2'd2
  } step_t;

  localparam logic [XY_W-1:0] XY_POS_SAT = {1'b0, {(XY_W - 1){1'b1}}};
  localparam logic [XY_W-1:0] XY_NEG_SAT = {1'b1, {(XY_W - 1){1'b0}}};

  state_t state, state_next;
  step_t  step;

  // Configuration registers.
  logic [SIZE_W-1:0]  frame_width, frame_height;
  logic [FOCAL_W-1:0] focal_px;
  logic [DEPTH_W-1:0] depth_scale, min_range_mm, max_range_mm;

  // Per-item working registers.
  logic [DEPTH_W-1:0] raw;
  pos_info_t          pos_q;
  logic [DEPTH_W-1:0] depth;
  logic [NUM_W-1:0]   prod;
  logic [XY_W-1:0]    x_q, y_q;
  logic [COLOR_W-1:0] red_q;

  pos_info_t          info;
  logic               in_acc, out_load, out_of_window;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [NUM_W-1:0]   mul_p;
  logic [DEPTH_W-1:0] depth_sat;
  logic [DEN_W-1:0]   div_den, focal_eff;
  logic               div_start, div_busy, div_done;
  logic [NUM_W-1:0]   div_quo;
  logic               depth_cap;
  logic [DEPTH_W-1:0] depth_hold;

  // Quotient to a negated, saturated 28-bit coordinate. A negative offset
  // gives a positive coordinate and the other way round.
  function automatic logic [XY_W-1:0] sat_xy(input logic [NUM_W-1:0] q, input logic neg);
    if (neg) begin
      return (q > NUM_W'(XY_POS_SAT)) ? XY_POS_SAT : q[XY_W-1:0];
    end
    return (q > NUM_W'(XY_NEG_SAT)) ? XY_NEG_SAT : XY_W'(NUM_W'(0) - q);
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign div_start = (state == ST_DSTART);

  dtpc_pos #(
    .MAX_LINE (MAX_LINE)
  ) u_pos (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_acc),
    .frame_start  (frame_start),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .info         (info)
  );

  // The one multiplier serves the depth scaling, both offset products and the
  // color ramp numerator.
  always_comb begin
    if (state == ST_SCALE) begin
      mul_a = raw;
      mul_b = depth_scale;
    end else begin
      unique case (step)
        STEP_X:   begin mul_a = pos_q.mag_x; mul_b = depth; end
        STEP_Y:   begin mul_a = pos_q.mag_y; mul_b = depth; end
        STEP_RED: begin mul_a = max_range_mm - depth; mul_b = MUL_W'(8'hFF); end
        default:  begin mul_a = '0; mul_b = '0; end
      endcase
    end
    mul_p = mul_a * mul_b;

    // Q8.8 scale result in millimetres, saturated to 16 bits.
    depth_sat = (prod[NUM_W-1:DEPTH_W+8] != '0) ? {DEPTH_W{1'b1}} : prod[DEPTH_W+7:8];

    out_of_window = (depth > max_range_mm) || (depth < min_range_mm);
    focal_eff     = (focal_px == '0) ? DEN_W'(1) : DEN_W'(focal_px);
    div_den       = (step == STEP_RED) ? max_range_mm : focal_eff;
  end

  dtpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        // Odd rows, odd columns and a zero sample produce nothing.
        if (in_acc && info.keep && depth_raw != '0) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:  state_next = ST_CHECK;
      ST_CHECK:  state_next = out_of_window ? ST_IDLE : ST_MUL;
      ST_MUL:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          state_next = (step == STEP_RED) ? ST_EMIT : ST_MUL;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      focal_px     <= RST_FOCAL_PX;
      depth_scale  <= RST_DEPTH_SCALE;
      min_range_mm <= RST_MIN_RANGE;
      max_range_mm <= RST_MAX_RANGE;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[SIZE_W-1:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data[SIZE_W-1:0];
          REG_FOCAL_PX:     focal_px     <= cfg_data[FOCAL_W-1:0];
          REG_DEPTH_SCALE:  depth_scale  <= cfg_data;
          REG_MIN_RANGE:    min_range_mm <= cfg_data;
          REG_MAX_RANGE:    max_range_mm <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers; these need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw   <= depth_raw;
      pos_q <= info;
    end
    if (state == ST_SCALE) begin
      prod <= mul_p;
    end
    if (state == ST_CHECK) begin
      step <= STEP_X;
    end else if (state == ST_MUL) begin
      prod <= mul_p;
    end
    if (state == ST_DWAIT && div_done) begin
      unique case (step)
        STEP_X: begin
          x_q  <= sat_xy(div_quo, pos_q.neg_x);
          step <= STEP_Y;
        end
        STEP_Y: begin
          y_q  <= sat_xy(div_quo, pos_q.neg_y);
          step <= STEP_RED;
        end
        STEP_RED: begin
          // A zero range span can only pass with zero depth; red is then zero.
          red_q <= (max_range_mm == '0) ? '0 : div_quo[COLOR_W-1:0];
        end
        default: ;
      endcase
    end
    if (out_load) begin
      x_mm  <= signed'(x_q);
      y_mm  <= signed'(y_q);
      z_mm  <= signed'(Z_W'(0) - Z_W'(depth));
      red   <= red_q;
      green <= red_q[COLOR_W-1:1];
      blue  <= ~red_q;
    end
  end

  // The saturated depth is captured in the window-check cycle, from the scale product
  // that the scaling state wrote into the shared product register.
  assign depth_cap = (state == ST_CHECK);
  always_comb begin
    depth = depth_cap ? depth_sat : depth_hold;
  end
  always_ff @(posedge clk) begin
    if (depth_cap) begin
      depth_hold <= depth_sat;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DWAIT))
    else $error("divider finished outside the wait state");

  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == ST_IDLE || state == ST_SCALE))
    else $error("accepted item did not start at the scale step");

  a_color: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((COLOR_W'(red + blue) == {COLOR_W{1'b1}}) && (green == red[COLOR_W-1:1])
                   && (z_mm <= 0)))
    else $error("result color ramp or depth sign inconsistent");
`endif

endmodule
